>>> design/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// shared constants, types and square geometry helpers for the playfair block
// ----------------------------------------------------------------------------
package pde_pkg;

   localparam int SQUARE_SIDE = 5;
   localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
   localparam int ALPHABET    = 26;
   localparam int LETTER_W    = 5;
   localparam int POS_W       = $clog2(CELL_COUNT);
   localparam int ROW_W       = $clog2(SQUARE_SIDE);
   localparam int SWEEP_W     = $clog2(ALPHABET + 1);

   localparam logic [LETTER_W-1:0] LETTER_I    = LETTER_W'(8);
   localparam logic [LETTER_W-1:0] LETTER_J    = LETTER_W'(9);
   localparam logic [LETTER_W-1:0] LETTER_X    = LETTER_W'(23);
   localparam logic [LETTER_W-1:0] LETTER_LAST = LETTER_W'(ALPHABET - 1);

   typedef enum logic [1:0] {
      CMD_KEY   = 2'd0,
      CMD_PLAIN = 2'd1,
      CMD_CLEAR = 2'd2
   } pde_command_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic decide;
      logic fill;
      logic plan;
      logic flush;
      logic pos;
      logic cell_rd;
      logic send_b;
   } pde_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_plain;
      logic complete;
      logic sweep_last;
      logic plan_pair;
      logic flush_pair;
      logic pair_last;
   } pde_status_type;

   function automatic logic [ROW_W-1:0] pos_row(input logic [POS_W-1:0] pos);
      logic [ROW_W-1:0] r;
      r = '0;
      for (int k = 1; k < SQUARE_SIDE; k++) begin
         if (pos >= POS_W'(k * SQUARE_SIDE)) r = r + ROW_W'(1);
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] pos_col(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] base;
      base = POS_W'(int'(pos_row(pos)) * SQUARE_SIDE);
      return ROW_W'(pos - base);
   endfunction

   function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] v);
      return (v == ROW_W'(SQUARE_SIDE - 1)) ? '0 : v + ROW_W'(1);
   endfunction

   function automatic logic [POS_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W-1:0] col);
      return POS_W'(int'(row) * SQUARE_SIDE + int'(col));
   endfunction

endpackage

>>> design/pde_datapath.sv
// ----------------------------------------------------------------------------
// pde_datapath
// key square storage, letter position table, pairing state and pair lookup
// ----------------------------------------------------------------------------
module pde_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  pde_pkg::pde_cmd_type             cmd,
   input  logic [1:0]                       req_command,
   input  logic [pde_pkg::LETTER_W-1:0]     req_letter,
   input  logic                             req_end,
   output pde_pkg::pde_status_type          stat,
   output logic [pde_pkg::LETTER_W-1:0]     cipher_letter,
   output logic                             last_of_run
);

   localparam int LW = pde_pkg::LETTER_W;
   localparam int PW = pde_pkg::POS_W;
   localparam int RW = pde_pkg::ROW_W;
   localparam int SW = pde_pkg::SWEEP_W;

   // item registers
   logic [1:0]      item_cmd_ff;
   logic [LW-1:0]   item_letter_ff;
   logic            item_end_ff;

   logic [pde_pkg::ALPHABET-1:0] used_ff, used_in;
   logic [SW-1:0]   fill_ff, fill_in;
   logic            complete_ff, complete_in;
   logic [LW-1:0]   held_ff, held_in;
   logic            held_valid_ff, held_valid_in;
   logic [SW-1:0]   sweep_ff, sweep_in;
   logic [LW-1:0]   pair_a_ff, pair_a_in;
   logic [LW-1:0]   pair_b_ff, pair_b_in;
   logic            pair_last_ff, pair_last_in;

   logic [PW-1:0]   pos_a_ff, pos_b_ff;
   logic [LW-1:0]   res_x_ff, res_y_ff;

   logic [LW-1:0]   cell_mem [pde_pkg::CELL_COUNT];
   logic [PW-1:0]   pos_mem  [pde_pkg::ALPHABET];

   logic            letter_ok;
   logic [LW-1:0]   plain_letter;
   logic [LW-1:0]   sweep_letter;
   logic            room;
   logic            key_ok;
   logic            fill_ok;
   logic            wr_en;
   logic [LW-1:0]   wr_letter;
   logic [PW-1:0]   wr_cell;
   logic [RW-1:0]   ra, ca, rb, cb;
   logic [RW-1:0]   xr, xc, yr, yc;

   assign letter_ok    = item_letter_ff <= pde_pkg::LETTER_LAST;
   assign plain_letter = (item_letter_ff == pde_pkg::LETTER_J) ? pde_pkg::LETTER_I
                                                               : item_letter_ff;
   assign sweep_letter = LW'(sweep_ff);
   assign room         = fill_ff < SW'(pde_pkg::CELL_COUNT);
   assign wr_cell      = PW'(fill_ff);

   assign key_ok  = !complete_ff && letter_ok && item_letter_ff != pde_pkg::LETTER_J &&
                    !used_ff[item_letter_ff] && room;
   assign fill_ok = sweep_letter != pde_pkg::LETTER_J && !used_ff[sweep_letter] && room;

   assign wr_en     = (cmd.decide && item_cmd_ff == pde_pkg::CMD_KEY && key_ok) ||
                      (cmd.fill && fill_ok);
   assign wr_letter = cmd.fill ? sweep_letter : item_letter_ff;

   // status
   assign stat.is_plain   = item_cmd_ff == pde_pkg::CMD_PLAIN;
   assign stat.complete   = complete_ff;
   assign stat.sweep_last = sweep_letter == pde_pkg::LETTER_LAST;
   assign stat.plan_pair  = letter_ok && held_valid_ff;
   assign stat.flush_pair = item_end_ff && held_valid_ff;
   assign stat.pair_last  = pair_last_ff;

   always_comb begin
      used_in       = used_ff;
      fill_in       = fill_ff;
      complete_in   = complete_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      sweep_in      = sweep_ff;
      pair_a_in     = pair_a_ff;
      pair_b_in     = pair_b_ff;
      pair_last_in  = pair_last_ff;

      if (wr_en) begin
         used_in = used_ff | (pde_pkg::ALPHABET'(1) << wr_letter);
         fill_in = fill_ff + SW'(1);
      end

      if (cmd.decide) begin
         sweep_in = '0;
         unique case (item_cmd_ff)
            pde_pkg::CMD_CLEAR: begin
               used_in       = '0;
               fill_in       = '0;
               complete_in   = 1'b0;
               held_in       = '0;
               held_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.fill) begin
         sweep_in = sweep_ff + SW'(1);
         if (stat.sweep_last) complete_in = 1'b1;
      end

      if (cmd.plan && letter_ok) begin
         if (!held_valid_ff) begin
            held_in       = plain_letter;
            held_valid_in = 1'b1;
         end else if (held_ff == plain_letter) begin
            // doubled letter: split with x filler, keep the letter held
            pair_a_in    = held_ff;
            pair_b_in    = pde_pkg::LETTER_X;
            pair_last_in = !item_end_ff;
         end else begin
            pair_a_in     = held_ff;
            pair_b_in     = plain_letter;
            pair_last_in  = 1'b1;
            held_in       = '0;
            held_valid_in = 1'b0;
         end
      end

      if (cmd.flush && stat.flush_pair) begin
         pair_a_in     = held_ff;
         pair_b_in     = pde_pkg::LETTER_X;
         pair_last_in  = 1'b1;
         held_in       = '0;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         fill_ff       <= '0;
         complete_ff   <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         sweep_ff      <= '0;
         pair_last_ff  <= 1'b0;
      end else begin
         used_ff       <= used_in;
         fill_ff       <= fill_in;
         complete_ff   <= complete_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         sweep_ff      <= sweep_in;
         pair_last_ff  <= pair_last_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_a_ff <= pair_a_in;
      pair_b_ff <= pair_b_in;
      if (cmd.latch) begin
         item_cmd_ff    <= req_command;
         item_letter_ff <= req_letter;
         item_end_ff    <= req_end;
      end
   end

   // pair geometry from looked-up positions
   always_comb begin
      ra = pde_pkg::pos_row(pos_a_ff);
      ca = pde_pkg::pos_col(pos_a_ff);
      rb = pde_pkg::pos_row(pos_b_ff);
      cb = pde_pkg::pos_col(pos_b_ff);
      if (ra == rb) begin
         xr = ra;
         xc = pde_pkg::wrap_inc(ca);
         yr = rb;
         yc = pde_pkg::wrap_inc(cb);
      end else if (ca == cb) begin
         xr = pde_pkg::wrap_inc(ra);
         xc = ca;
         yr = pde_pkg::wrap_inc(rb);
         yc = cb;
      end else begin
         xr = ra;
         xc = cb;
         yr = rb;
         yc = ca;
      end
   end

   // square and position memories, one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_cell]  <= wr_letter;
         pos_mem[wr_letter] <= wr_cell;
      end
      if (cmd.pos) begin
         pos_a_ff <= pos_mem[pair_a_ff];
         pos_b_ff <= pos_mem[pair_b_ff];
      end
      if (cmd.cell_rd) begin
         res_x_ff <= cell_mem[pde_pkg::cell_index(xr, xc)];
         res_y_ff <= cell_mem[pde_pkg::cell_index(yr, yc)];
      end
   end

   assign cipher_letter = cmd.send_b ? res_y_ff : res_x_ff;
   assign last_of_run   = cmd.send_b && pair_last_ff;

endmodule

>>> design/pde_ctrl.sv
// ----------------------------------------------------------------------------
// pde_ctrl
// sequencer for item decode, square completion, pair lookup and result send
// ----------------------------------------------------------------------------
module pde_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  pde_pkg::pde_status_type stat,
   output pde_pkg::pde_cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECIDE = 9'b000000010,
      ST_FILL   = 9'b000000100,
      ST_PLAN   = 9'b000001000,
      ST_FLUSH  = 9'b000010000,
      ST_POS    = 9'b000100000,
      ST_CELL   = 9'b001000000,
      ST_SEND_A = 9'b010000000,
      ST_SEND_B = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_SEND_A || state_ff == ST_SEND_B;

   assign cmd.latch   = req_tvalid && req_tready;
   assign cmd.decide  = state_ff == ST_DECIDE;
   assign cmd.fill    = state_ff == ST_FILL;
   assign cmd.plan    = state_ff == ST_PLAN;
   assign cmd.flush   = state_ff == ST_FLUSH;
   assign cmd.pos     = state_ff == ST_POS;
   assign cmd.cell_rd = state_ff == ST_CELL;
   assign cmd.send_b  = state_ff == ST_SEND_B;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!stat.is_plain)     state_in = ST_IDLE;
            else if (stat.complete) state_in = ST_PLAN;
            else                    state_in = ST_FILL;
         end
         ST_FILL:   if (stat.sweep_last) state_in = ST_PLAN;
         ST_PLAN:   state_in = stat.plan_pair ? ST_POS : ST_FLUSH;
         ST_FLUSH:  state_in = stat.flush_pair ? ST_POS : ST_IDLE;
         ST_POS:    state_in = ST_CELL;
         ST_CELL:   state_in = ST_SEND_A;
         ST_SEND_A: if (rsp_tready) state_in = ST_SEND_B;
         ST_SEND_B: begin
            if (rsp_tready) state_in = stat.pair_last ? ST_IDLE : ST_FLUSH;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/playfair_digraph_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// playfair encryptor: builds a 5x5 key square from key letters, pairs
// plaintext letters and sends the cipher letters of each pair
// ----------------------------------------------------------------------------
// one item at a time: key, clear and ignored items pass through decide only
// a plaintext item goes decide, plan, then flush or, for a pair, pos, cell,
// send a and send b; with end of text a held letter is sent as a flush pair
// with x filler, alone or after a pair
// first plaintext after a clear or reset adds a completion sweep of the alphabet
// each pair takes two registered memory reads (position, then cell)
// reset clears control state and the square bookkeeping; memories are not swept
module playfair_digraph_encrypt (
   input  logic       clock,
   input  logic       reset,
   // input items
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [4:0] letter, [7:5] zero
   input  logic [1:0] req_tuser,   // [1:0] command
   input  logic       req_tlast,   // end of text
   // result items
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [4:0] cipher letter, [7:5] zero
   output logic       rsp_tlast    // last result of the input item
);

   pde_pkg::pde_cmd_type    cmd;
   pde_pkg::pde_status_type stat;
   logic [pde_pkg::LETTER_W-1:0] cipher_letter;

   // sequencer
   pde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // square storage and pair lookup
   pde_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_command   (req_tuser),
      .req_letter    (req_tdata[pde_pkg::LETTER_W-1:0]),
      .req_end       (req_tlast),
      .stat          (stat),
      .cipher_letter (cipher_letter),
      .last_of_run   (rsp_tlast)
   );

   // letter in the low bits, zero fill up to the byte
   assign rsp_tdata = {{(8 - pde_pkg::LETTER_W){1'b0}}, cipher_letter};

   // no new item while a result is pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result is pending");

   // lookups only run on a completed square
   a_square_done: assert property (@(posedge clock) disable iff (reset)
      cmd.pos |-> stat.complete)
      else $error("pair lookup before square completion");

   // the last result of an item frees the input side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("input not ready after last result");

endmodule
